// ===== hdl/dmhs_pkg.sv =====
// Shared constants for the DICOM file meta header stripper.
`timescale 1ns / 1ps

package dmhs_pkg;

    localparam int unsigned PREAMBLE_BYTES_DEF = 128;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
    localparam logic [STATUS_W-1:0] ST_MAGIC_TRUNC = 4'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TAG_TRUNC   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_VR      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_VL      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_GLEN_TRUNC  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_SKIP_TRUNC  = 4'd8;

    // Expected header fields, little-endian as assembled
    localparam logic [31:0] MAGIC_LE    = 32'h4D43_4944;  // "DICM"
    localparam logic [31:0] TAG_LE      = 32'h0000_0002;  // (0002,0000)
    localparam logic [31:0] VR_UL_LE    = 32'h0000_4C55;  // "UL"
    localparam logic [31:0] VL_EXPECTED = 32'h0000_0004;

endpackage

// ===== hdl/dmhs_if.sv =====
// Stream channel interfaces for the header stripper input and output.
`timescale 1ns / 1ps

interface dmhs_in_if;
    logic                              valid;
    logic                              ready;
    logic [dmhs_pkg::BYTE_W-1:0]       data_byte;
    logic                              end_marker;

    modport source (output valid, output data_byte, output end_marker, input ready);
    modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

interface dmhs_out_if;
    logic                              valid;
    logic                              ready;
    logic [dmhs_pkg::BYTE_W-1:0]       out_byte;
    logic [dmhs_pkg::STATUS_W-1:0]     status;
    logic                              stream_done;

    modport source (output valid, output out_byte, output status, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input stream_done,
                    output ready);
endinterface

// ===== hdl/dicom_meta_header_stripper.sv =====
// Top level: DICOM Part 10 file meta header stripper, one byte per item.
// Results are registered before they reach dout. Throughput: one item per cycle;
// the single output register is reloaded in the cycle it is taken, so din.ready
// only drops while a result waits on dout. Reset (rst_n, async, active low)
// returns the parser to the preamble phase, or to magic if PREAMBLE_BYTES is 0,
// and empties the output register; after a final result the block drops items.
`timescale 1ns / 1ps

module dicom_meta_header_stripper #(
    parameter int unsigned PREAMBLE_BYTES = dmhs_pkg::PREAMBLE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    dmhs_in_if.sink          din,
    dmhs_out_if.source       dout
);

    localparam logic [3:0] PH_PREAMBLE = 4'd0;
    localparam logic [3:0] PH_MAGIC    = 4'd1;
    localparam logic [3:0] PH_TAG      = 4'd2;
    localparam logic [3:0] PH_VR       = 4'd3;
    localparam logic [3:0] PH_VL       = 4'd4;
    localparam logic [3:0] PH_GLEN     = 4'd5;
    localparam logic [3:0] PH_SKIP     = 4'd6;
    localparam logic [3:0] PH_PASS     = 4'd7;
    localparam logic [3:0] PH_HALT     = 4'd8;

    localparam logic [7:0] PRE_LEN  = 8'(PREAMBLE_BYTES);
    localparam logic [3:0] PH_RESET = (PRE_LEN == 8'd0) ? PH_MAGIC : PH_PREAMBLE;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] skip_reg, skip_next;

    logic                               out_valid_reg, out_valid_next;
    logic [dmhs_pkg::BYTE_W-1:0]        out_byte_reg;
    logic [dmhs_pkg::STATUS_W-1:0]      status_reg;
    logic                               done_reg;

    logic                               accept;
    logic                               res_valid;
    logic [dmhs_pkg::BYTE_W-1:0]        res_byte;
    logic [dmhs_pkg::STATUS_W-1:0]      res_status;
    logic                               res_done;

    logic [31:0] field_merged;
    logic [7:0]  pos_inc;
    logic [7:0]  field_len;
    logic [31:0] skip_dec;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    assign pos_inc   = pos_reg + 8'd1;
    assign skip_dec  = skip_reg - 32'd1;
    assign field_len = (phase_reg == PH_VR || phase_reg == PH_VL) ? 8'd2 : 8'd4;

    // drop the new byte into its little-endian lane
    always_comb
    begin
        field_merged = field_reg;
        case (pos_reg[1:0])
            2'd0:    field_merged[7:0]   = field_reg[7:0]   | din.data_byte;
            2'd1:    field_merged[15:8]  = field_reg[15:8]  | din.data_byte;
            2'd2:    field_merged[23:16] = field_reg[23:16] | din.data_byte;
            default: field_merged[31:24] = field_reg[31:24] | din.data_byte;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        field_next = field_reg;
        skip_next  = skip_reg;
        res_valid  = 1'b0;
        res_byte   = '0;
        res_status = dmhs_pkg::ST_OK;
        res_done   = 1'b0;

        if (accept && phase_reg != PH_HALT)
        begin
            if (din.end_marker)
            begin
                res_valid  = 1'b1;
                res_done   = 1'b1;
                phase_next = PH_HALT;
                case (phase_reg)
                    PH_PREAMBLE, PH_MAGIC: res_status = dmhs_pkg::ST_MAGIC_TRUNC;
                    PH_TAG:                res_status = dmhs_pkg::ST_TAG_TRUNC;
                    PH_VR:                 res_status = dmhs_pkg::ST_BAD_VR;
                    PH_VL:                 res_status = dmhs_pkg::ST_BAD_VL;
                    PH_GLEN:               res_status = dmhs_pkg::ST_GLEN_TRUNC;
                    PH_SKIP:               res_status = dmhs_pkg::ST_SKIP_TRUNC;
                    default:               res_status = dmhs_pkg::ST_OK;
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_PREAMBLE:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= PRE_LEN)
                        begin
                            phase_next = PH_MAGIC;
                            pos_next   = '0;
                            field_next = '0;
                        end
                    end
                    PH_MAGIC, PH_TAG, PH_VR, PH_VL, PH_GLEN:
                    begin
                        field_next = field_merged;
                        pos_next   = pos_inc;
                        if (pos_inc >= field_len)
                        begin
                            pos_next   = '0;
                            field_next = '0;
                            case (phase_reg)
                                PH_MAGIC:
                                    if (field_merged != dmhs_pkg::MAGIC_LE)
                                    begin
                                        res_valid  = 1'b1;
                                        res_done   = 1'b1;
                                        res_status = dmhs_pkg::ST_BAD_MAGIC;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                        phase_next = PH_TAG;
                                PH_TAG:
                                    if (field_merged != dmhs_pkg::TAG_LE)
                                    begin
                                        res_valid  = 1'b1;
                                        res_done   = 1'b1;
                                        res_status = dmhs_pkg::ST_BAD_TAG;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                        phase_next = PH_VR;
                                PH_VR:
                                    if (field_merged != dmhs_pkg::VR_UL_LE)
                                    begin
                                        res_valid  = 1'b1;
                                        res_done   = 1'b1;
                                        res_status = dmhs_pkg::ST_BAD_VR;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                        phase_next = PH_VL;
                                PH_VL:
                                    if (field_merged != dmhs_pkg::VL_EXPECTED)
                                    begin
                                        res_valid  = 1'b1;
                                        res_done   = 1'b1;
                                        res_status = dmhs_pkg::ST_BAD_VL;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                        phase_next = PH_GLEN;
                                default:
                                begin
                                    // group length: zero starts payload at once
                                    skip_next  = field_merged;
                                    phase_next = (field_merged == 32'd0) ? PH_PASS : PH_SKIP;
                                end
                            endcase
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0)
                        begin
                            phase_next = PH_PASS;
                            pos_next   = '0;
                            field_next = '0;
                        end
                    end
                    PH_PASS:
                    begin
                        res_valid = 1'b1;
                        res_byte  = din.data_byte;
                    end
                    default:
                        phase_next = PH_HALT;
                endcase
            end
        end
    end

    always_comb
    begin
        if (res_valid)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RESET;
            pos_reg       <= '0;
            field_reg     <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            field_reg     <= field_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_byte_reg <= res_byte;
            status_reg   <= res_status;
            done_reg     <= res_done;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.out_byte    = out_byte_reg;
    assign dout.status      = status_reg;
    assign dout.stream_done = done_reg;

endmodule

// ===== hdl/dmhs_checker.sv =====
// Port-level assertions for the header stripper, bound to the top level.
`timescale 1ns / 1ps

module dmhs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [dmhs_pkg::BYTE_W-1:0]       out_byte,
    input logic [dmhs_pkg::STATUS_W-1:0]     status,
    input logic                              stream_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(stream_done))
        else $error("dmhs: stalled result changed");

    // any error code ends the stream
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dmhs_pkg::ST_OK |-> stream_done)
        else $error("dmhs: error result without stream_done");

    // final items carry no byte
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> out_byte == '0)
        else $error("dmhs: final item carries a byte");

    // nothing follows a taken final item
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stream_done |=> !out_valid)
        else $error("dmhs: item after end of stream");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= dmhs_pkg::ST_SKIP_TRUNC)
        else $error("dmhs: status code out of range");

endmodule

bind dicom_meta_header_stripper dmhs_checker u_dmhs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .out_byte    (dout.out_byte),
    .status      (dout.status),
    .stream_done (dout.stream_done)
);
